// ----- hw/rtl/ctbb_pkg.sv -----
// Shared types, constants and the edge clip function for the clipped tile blitter.
// No dependencies; every other file of the block imports this package.
package ctbb_pkg;

  localparam int unsigned POS_W      = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned ADDR_W     = 10;
  localparam int unsigned BLOCK_SIZE = 6;
  localparam int unsigned BIDX_W     = 3;   // holds a cell index 0..BLOCK_SIZE-1
  localparam int unsigned LIM_W      = 7;   // holds a window size up to 127
  localparam int unsigned SPOS_W     = 10;  // signed working width for clipping

  typedef struct packed {
    logic                     req_type;
    logic signed [POS_W-1:0]  x_pos;
    logic signed [POS_W-1:0]  y_pos;
    logic        [CODE_W-1:0] code;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_addr;
    logic [CODE_W-1:0] write_code;
    logic              last;
  } wr_t;

  // Visible index range along one axis of the block.
  typedef struct packed {
    logic              empty;
    logic [BIDX_W-1:0] lo;
    logic [BIDX_W-1:0] hi;
  } clip_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture an accepted request
    logic clip;     // register the visible ranges
    logic place;    // set up first visible cell
    logic advance;  // step to the next visible cell
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // nothing of the request is visible
    logic last;     // current cell is the final visible one
  } dp_stat_t;

  function automatic clip_t clip_axis(logic signed [POS_W-1:0] pos, logic blk,
                                      logic [LIM_W-1:0] limit);
    logic signed [SPOS_W-1:0] p;
    logic signed [SPOS_W-1:0] smax;
    logic signed [SPOS_W-1:0] lim;
    logic signed [SPOS_W-1:0] tail;
    logic signed [SPOS_W-1:0] neg;
    clip_t                    res;
    p     = pos;
    smax  = blk ? SPOS_W'(BLOCK_SIZE - 1) : '0;
    lim   = signed'({{(SPOS_W-LIM_W){1'b0}}, limit});
    tail  = lim - SPOS_W'(1) - p;
    neg   = -p;
    res.empty = ((p + smax) < 0) || (p >= lim);
    res.lo    = (p < 0) ? neg[BIDX_W-1:0] : '0;
    res.hi    = (tail < smax) ? tail[BIDX_W-1:0] : smax[BIDX_W-1:0];
    return res;
  endfunction

endpackage

// ----- hw/rtl/ctbb_ctrl.sv -----
// Controller state machine of the clipped tile blitter.
// Depends on ctbb_pkg for the command and status structs.
module ctbb_ctrl import ctbb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLIP,
    ST_PLACE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  assign cmd_o.load    = in_valid_i && in_ready_q;
  assign cmd_o.clip    = (state_q == ST_CLIP);
  assign cmd_o.place   = (state_q == ST_PLACE);
  assign cmd_o.advance = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q    <= ST_CLIP;
            in_ready_q <= 1'b0;
          end
        end
        ST_CLIP: begin
          state_q <= ST_PLACE;
        end
        ST_PLACE: begin
          // drop a fully clipped request
          if (stat_i.empty) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end else begin
            state_q     <= ST_EMIT;
            out_valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready_i && stat_i.last) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/ctbb_dp.sv -----
// Datapath of the clipped tile blitter: request register, clip ranges, cell walker.
// Depends on ctbb_pkg for types, constants and the clip function.
module ctbb_dp import ctbb_pkg::*; #(
  parameter int unsigned WINDOW_COLS = 24,
  parameter int unsigned WINDOW_ROWS = 24
) (
  input  logic     clk_i,
  input  req_t     req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output wr_t      wr_o
);

  localparam int unsigned AW   = $clog2(WINDOW_COLS * WINDOW_ROWS);
  localparam int unsigned AXW  = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int unsigned ROWW = $clog2(WINDOW_ROWS);
  localparam int unsigned COLW = $clog2(WINDOW_COLS);

  req_t              req_q;
  clip_t             cx_q;
  clip_t             cy_q;
  logic              empty_q;
  logic [BIDX_W-1:0] k_q, k_d;
  logic [BIDX_W-1:0] r_q, r_d;
  logic [AXW-1:0]    addr_q, addr_d;
  logic [CODE_W-1:0] code_q, code_d;

  clip_t                    cx_c;
  clip_t                    cy_c;
  logic signed [SPOS_W-1:0] row0;
  logic signed [SPOS_W-1:0] col0;
  logic [BIDX_W-1:0]        span;
  logic                     last_c;

  assign cx_c = clip_axis(req_q.x_pos, req_q.req_type, LIM_W'(WINDOW_COLS));
  assign cy_c = clip_axis(req_q.y_pos, req_q.req_type, LIM_W'(WINDOW_ROWS));

  assign row0 = SPOS_W'(req_q.y_pos) + signed'({{(SPOS_W-BIDX_W){1'b0}}, cy_q.lo});
  assign col0 = SPOS_W'(req_q.x_pos) + signed'({{(SPOS_W-BIDX_W){1'b0}}, cx_q.lo});
  assign span = cx_q.hi - cx_q.lo;

  assign last_c = (r_q == cy_q.hi) && (k_q == cx_q.hi);

  always_comb begin
    k_d    = k_q;
    r_d    = r_q;
    addr_d = addr_q;
    code_d = code_q;
    if (cmd_i.place) begin
      k_d    = cx_q.lo;
      r_d    = cy_q.lo;
      addr_d = AXW'(row0[ROWW-1:0]) * AXW'(WINDOW_COLS) + AXW'(col0[COLW-1:0]);
      code_d = req_q.code + CODE_W'(BLOCK_SIZE) * CODE_W'(cy_q.lo) + CODE_W'(cx_q.lo);
    end else if (cmd_i.advance) begin
      if (k_q == cx_q.hi) begin
        // wrap to the first visible column of the next row
        k_d    = cx_q.lo;
        r_d    = r_q + BIDX_W'(1);
        addr_d = addr_q + AXW'(WINDOW_COLS) - AXW'(span);
        code_d = code_q + CODE_W'(BLOCK_SIZE) - CODE_W'(span);
      end else begin
        k_d    = k_q + BIDX_W'(1);
        addr_d = addr_q + AXW'(1);
        code_d = code_q + CODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.clip) begin
      cx_q    <= cx_c;
      cy_q    <= cy_c;
      empty_q <= cx_c.empty || cy_c.empty;
    end
    k_q    <= k_d;
    r_q    <= r_d;
    addr_q <= addr_d;
    code_q <= code_d;
  end

  assign stat_o.empty = empty_q;
  assign stat_o.last  = last_c;

  assign wr_o.write_addr = addr_q[ADDR_W-1:0];
  assign wr_o.write_code = code_q;
  assign wr_o.last       = last_c;

endmodule

// ----- hw/rtl/clipped_tile_block_blitter.sv -----
// Top level of the clipped tile blitter: request channel in, buffer write channel out.
// Depends on ctbb_pkg, ctbb_ctrl and ctbb_dp.
//
// Usage:
//   A request transaction (in_valid_i/in_ready_o, payload in_req_i) places either
//   one character or a 6x6 block of consecutive codes at a signed position.
//   Each visible cell yields one write transaction (out_valid_o/out_ready_i,
//   payload out_wr_o) with address row*WINDOW_COLS+column and its code;
//   the final write of a request carries last. Cells cut off at the left or
//   top edge still advance the code; codes wrap modulo 256.
// Timing:
//   After acceptance the controller registers the visible ranges in ST_CLIP
//   and places the first cell in ST_PLACE, then emits one write per cycle
//   while the receiver takes them. A fully clipped request returns from
//   ST_PLACE to idle and produces nothing. The single output register paces
//   the walk, one cell per cycle while the receiver takes it, and a new
//   request is taken only after the last write.
// Reset and stalls:
//   Reset returns the controller to idle with in_ready_o high and no write
//   pending. When the receiver stalls, hold the current write unchanged.
module clipped_tile_block_blitter import ctbb_pkg::*; #(
  parameter int unsigned WINDOW_COLS = 24,
  parameter int unsigned WINDOW_ROWS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output wr_t  out_wr_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the request: accept, clip, place, then emit visible cells.
  ctbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the request, the visible ranges and the current cell.
  ctbb_dp #(
    .WINDOW_COLS (WINDOW_COLS),
    .WINDOW_ROWS (WINDOW_ROWS)
  ) u_dp (
    .clk_i  (clk_i),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .wr_o   (out_wr_o)
  );

  // Never take a request while a write is pending.
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a write is pending");

  // Close the request once its final write is taken.
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_wr_o.last) |=> (in_ready_o && !out_valid_o))
    else $error("block not idle after final write");

  // Keep every write address inside the window.
  a_addr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_wr_o.write_addr) < 32'(WINDOW_COLS * WINDOW_ROWS)
                     || (WINDOW_COLS * WINDOW_ROWS) > 1024))
    else $error("write address outside the window");

  // Drop ready for the cycle after a request transaction.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after request accepted");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for clipped_tile_block_blitter: drives draw request transactions
// and checks each buffer write transaction against a behavioural blit predictor.
// Depends on ctbb_pkg and the clipped_tile_block_blitter RTL only.
`timescale 1ns / 100ps

module tb_top;
  import ctbb_pkg::*;

  // Window of the instance under test; the predictor uses the same figures.
  localparam int unsigned WIN_COLS = 24;
  localparam int unsigned WIN_ROWS = 24;

  // Request kinds carried in req_type.
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_BLOCK = 1'b1;

  // After the last owed write has gone, wait SETTLE_CYCLES more so a stray
  // write still gets caught.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Watchdog limit, well above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  typedef wr_t wr_q_t[$];

  // How a directed row is checked: typed-in writes or the blit predictor.
  typedef enum logic [1:0] {
    CHK_MODEL,   // expected writes come from blit_writes()
    CHK_NONE,    // fully clipped: no write at all
    CHK_ONE      // exactly the single write typed into the row
  } chk_kind_e;

  typedef struct packed {
    req_t      req;
    chk_kind_e how;
    wr_t       one_wr;
  } dir_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_req_i    = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  wr_t  out_wr_o;

  wr_t pending_writes[$];     // writes still owed by the block, oldest first
  int  error_count     = 0;
  int  cycle_count     = 0;
  int  send_idle_pct   = 0;   // chance in a hundred that the sender idles a cycle
  int  stall_pct       = 0;   // chance in a hundred that the receiver stalls a cycle
  int  hold_off_left   = 0;   // cycles of forced receiver hold-off still to run

  clipped_tile_block_blitter #(
    .WINDOW_COLS(WIN_COLS),
    .WINDOW_ROWS(WIN_ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_wr_o   (out_wr_o)
  );

  // Directed rows: window corners, every edge just outside, the far ends of the
  // signed range, code wrap and blocks cut by each edge. Positions are raw bytes,
  // so 8'hFB is -5 and 8'h80 is -128.
  dir_row_t directed_rows [23] = '{
    // single character at the origin and at the far corner
    '{'{REQ_CHAR,  8'h00, 8'h00, 8'h41}, CHK_ONE,  '{10'd0,   8'h41, 1'b1}},
    '{'{REQ_CHAR,  8'h17, 8'h17, 8'hFF}, CHK_ONE,  '{10'd575, 8'hFF, 1'b1}},
    // single character one step outside each edge, and at the range ends
    '{'{REQ_CHAR,  8'h18, 8'h00, 8'h12}, CHK_NONE, '0},
    '{'{REQ_CHAR,  8'h00, 8'h18, 8'h34}, CHK_NONE, '0},
    '{'{REQ_CHAR,  8'hFF, 8'h00, 8'h56}, CHK_NONE, '0},
    '{'{REQ_CHAR,  8'h00, 8'hFF, 8'h78}, CHK_NONE, '0},
    '{'{REQ_CHAR,  8'h7F, 8'h7F, 8'h00}, CHK_NONE, '0},
    '{'{REQ_CHAR,  8'h80, 8'h80, 8'hFF}, CHK_NONE, '0},
    // blocks that miss the window entirely
    '{'{REQ_BLOCK, 8'h80, 8'h80, 8'h00}, CHK_NONE, '0},
    '{'{REQ_BLOCK, 8'h7F, 8'h7F, 8'hFF}, CHK_NONE, '0},
    '{'{REQ_BLOCK, 8'hFA, 8'h00, 8'h20}, CHK_NONE, '0},
    '{'{REQ_BLOCK, 8'h00, 8'hFA, 8'h30}, CHK_NONE, '0},
    '{'{REQ_BLOCK, 8'h18, 8'h00, 8'h40}, CHK_NONE, '0},
    // blocks with only one visible cell: top-left corner at the far corner,
    // bottom-right corner at the origin (code 0xFA + 35 wraps to 0x1D)
    '{'{REQ_BLOCK, 8'h17, 8'h17, 8'hFF}, CHK_ONE,  '{10'd575, 8'hFF, 1'b1}},
    '{'{REQ_BLOCK, 8'hFB, 8'hFB, 8'hFA}, CHK_ONE,  '{10'd0,   8'h1D, 1'b1}},
    // full blocks, one wrapping its codes
    '{'{REQ_BLOCK, 8'h00, 8'h00, 8'h00}, CHK_MODEL, '0},
    '{'{REQ_BLOCK, 8'h12, 8'h12, 8'hF0}, CHK_MODEL, '0},
    '{'{REQ_BLOCK, 8'h0A, 8'h0A, 8'hDB}, CHK_MODEL, '0},
    // blocks cut by the left, top, right/bottom and top-left edges, then one character inside
    '{'{REQ_BLOCK, 8'hFD, 8'h02, 8'h10}, CHK_MODEL, '0},
    '{'{REQ_BLOCK, 8'h04, 8'hFE, 8'h80}, CHK_MODEL, '0},
    '{'{REQ_BLOCK, 8'h15, 8'h14, 8'h55}, CHK_MODEL, '0},
    '{'{REQ_BLOCK, 8'hFF, 8'hFF, 8'hFE}, CHK_MODEL, '0},
    '{'{REQ_CHAR,  8'h05, 8'h07, 8'hAA}, CHK_MODEL, '0}
  };

  // Predict the writes one request causes: visible cells in row order, left to
  // right, each keeping the code it would have had unclipped; mark the final one.
  function automatic wr_q_t blit_writes(req_t req);
    wr_q_t writes;
    wr_t   wr;
    int    span;
    int    r_i;
    int    k_i;
    int    col;
    int    row;
    span = (req.req_type == REQ_BLOCK) ? BLOCK_SIZE : 1;
    for (r_i = 0; r_i < span; r_i++) begin
      for (k_i = 0; k_i < span; k_i++) begin
        col = int'(req.x_pos) + k_i;
        row = int'(req.y_pos) + r_i;
        if (col >= 0 && col < int'(WIN_COLS) && row >= 0 && row < int'(WIN_ROWS)) begin
          wr.write_addr = ADDR_W'(row * WIN_COLS + col);
          wr.write_code = req.code + CODE_W'(BLOCK_SIZE * r_i + k_i);
          wr.last       = 1'b0;
          writes.push_back(wr);
        end
      end
    end
    if (writes.size() != 0) begin
      writes[writes.size() - 1].last = 1'b1;
    end
    return writes;
  endfunction

  // Mostly land near the window so clipping on every edge gets exercised;
  // the rest covers the whole signed range.
  function automatic logic signed [POS_W-1:0] random_pos();
    if ($urandom_range(99) < 75) begin
      return POS_W'($urandom_range(WIN_COLS + 11) - 8);
    end else begin
      return POS_W'($urandom());
    end
  endfunction

  function automatic req_t random_request();
    req_t req;
    req.req_type = ($urandom_range(99) < 80) ? REQ_BLOCK : REQ_CHAR;
    req.x_pos    = random_pos();
    req.y_pos    = random_pos();
    req.code     = CODE_W'($urandom());
    return req;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offer one request transaction; on acceptance queue the writes it owes.
  // Valid stays high from one request to the next unless the sender idles,
  // so it is never lowered and raised in the same time step.
  task automatic offer_request(input req_t req, input wr_q_t writes);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_writes = {pending_writes, writes};
  endtask

  // Pause the sender until every owed write has arrived, then let the settle period run.
  task automatic drain_writes();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_chance, input int count);
    req_t req;
    send_idle_pct = idle_pct;
    stall_pct     = stall_chance;
    repeat (count) begin
      req = random_request();
      offer_request(req, blit_writes(req));
    end
    drain_writes();
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: stall at random, or hold off entirely while a forced stretch runs.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every write transaction against the oldest owed write, field by field.
  always @(posedge clk_i) begin
    wr_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unowed write, addr", int'(out_wr_o.write_addr), -1);
      end else begin
        want = pending_writes.pop_front();
        if (out_wr_o.write_addr !== want.write_addr) begin
          report_mismatch("write_addr", int'(out_wr_o.write_addr), int'(want.write_addr));
        end
        if (out_wr_o.write_code !== want.write_code) begin
          report_mismatch("write_code", int'(out_wr_o.write_code), int'(want.write_code));
        end
        if (out_wr_o.last !== want.last) begin
          report_mismatch("last", int'(out_wr_o.last), int'(want.last));
        end
      end
    end
  end

  // Watchdog: give up if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    wr_q_t writes;
    int    row_i;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling on either side.
    for (row_i = 0; row_i < $size(directed_rows); row_i++) begin
      writes = {};
      case (directed_rows[row_i].how)
        CHK_ONE: begin
          writes.push_back(directed_rows[row_i].one_wr);
        end
        CHK_MODEL: begin
          writes = blit_writes(directed_rows[row_i].req);
        end
        default: begin
        end
      endcase
      offer_request(directed_rows[row_i].req, writes);
    end
    drain_writes();

    // Random traffic, flat out first.
    random_phase(0, 0, 100);

    // Back-pressure: hold the receiver off for a long stretch while the sender
    // keeps offering, so the block fills and stalls its request side.
    hold_off_left = HOLD_OFF_CYCLES;
    random_phase(0, 0, 30);

    // Sparse sender, stalling receiver, then both idling now and then.
    random_phase(85, 0, 95);
    random_phase(0, 85, 95);
    random_phase(22, 22, 100);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ctbb_pkg.sv
hw/rtl/ctbb_ctrl.sv
hw/rtl/ctbb_dp.sv
hw/rtl/clipped_tile_block_blitter.sv
dv/tb_top.sv
